// ===== design/mmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrb_pkg
// shared types and constants for the min/max rescale-to-byte block
// ----------------------------------------------------------------------------
package mmrb_pkg;

    // sample and arithmetic widths
    localparam int SampleW = 32;
    localparam int RangeW  = 32;
    localparam int ByteW   = 8;
    localparam int QuotBits = ByteW;
    localparam int CntW    = $clog2(QuotBits);
    // numerator d*510 + range needs nine more bits than the range
    localparam int NumW    = RangeW + 9;
    // divisor 2*range
    localparam int DenW    = RangeW + 1;
    // partial remainder stays below the divisor
    localparam int RemW    = DenW;

    // input word kinds
    localparam logic KindMeasure = 1'b0;
    localparam logic KindConvert = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_PREP,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clamp;
        logic prep;
        logic num;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== design/mmrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmrb_ctrl
// sequencer for one word at a time: clamp, prepare, divide, hand off result
// ----------------------------------------------------------------------------
module mmrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_kind,
    input  mmrb_pkg::t_sts   i_sts,
    output logic             o_in_ready,
    output mmrb_pkg::t_cmd   o_cmd
);

    mmrb_pkg::t_state r_state;
    mmrb_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == mmrb_pkg::ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmrb_pkg::ST_IDLE: begin
                if (accept && (i_kind == mmrb_pkg::KindConvert)) begin
                    n_state = mmrb_pkg::ST_CLAMP;
                end
            end
            mmrb_pkg::ST_CLAMP: n_state = mmrb_pkg::ST_PREP;
            mmrb_pkg::ST_PREP:  n_state = mmrb_pkg::ST_NUM;
            mmrb_pkg::ST_NUM:   n_state = mmrb_pkg::ST_DIV;
            mmrb_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = mmrb_pkg::ST_DONE;
                end
            end
            mmrb_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = mmrb_pkg::ST_IDLE;
                end
            end
            default: n_state = mmrb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mmrb_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = accept;
            end
            mmrb_pkg::ST_CLAMP: o_cmd.clamp    = 1'b1;
            mmrb_pkg::ST_PREP:  o_cmd.prep     = 1'b1;
            mmrb_pkg::ST_NUM:   o_cmd.num      = 1'b1;
            mmrb_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            mmrb_pkg::ST_DONE:  o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/mmrb_dpath.sv =====
// ----------------------------------------------------------------------------
// mmrb_dpath
// bound tracking, clamp, numerator build, radix-2 restoring divider, output
// ----------------------------------------------------------------------------
module mmrb_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmrb_pkg::t_cmd                  i_cmd,
    input  logic                            i_kind,
    input  logic                            i_first,
    input  logic signed [mmrb_pkg::SampleW-1:0] i_sample,
    input  logic                            i_out_ready,
    output mmrb_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    output logic [mmrb_pkg::ByteW-1:0]      o_byte_value
);

    logic signed [mmrb_pkg::SampleW-1:0] r_lo;
    logic signed [mmrb_pkg::SampleW-1:0] r_hi;
    logic signed [mmrb_pkg::SampleW-1:0] r_x;
    logic signed [mmrb_pkg::SampleW-1:0] r_xs;
    logic [mmrb_pkg::RangeW-1:0]         r_d;
    logic [mmrb_pkg::RangeW-1:0]         r_range;
    logic                                r_zero;
    logic [mmrb_pkg::RemW-1:0]           r_rem;
    logic [mmrb_pkg::QuotBits-1:0]       r_nlow;
    logic [mmrb_pkg::DenW-1:0]           r_den;
    logic [mmrb_pkg::QuotBits-1:0]       r_q;
    logic [mmrb_pkg::CntW-1:0]           r_cnt;
    logic                                r_out_valid;
    logic [mmrb_pkg::ByteW-1:0]          r_out_byte;

    logic signed [mmrb_pkg::SampleW:0]   diff_d;
    logic signed [mmrb_pkg::SampleW:0]   diff_r;
    logic [mmrb_pkg::NumW-1:0]           num;
    logic [mmrb_pkg::RemW:0]             rem_sh;
    logic [mmrb_pkg::RemW:0]             rem_sub;
    logic                                q_bit;

    // running minimum and maximum, updated on a measure word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cmd.capture && (i_kind == mmrb_pkg::KindMeasure)) begin
            if (i_first) begin
                r_lo <= i_sample;
                r_hi <= i_sample;
            end else begin
                if (i_sample < r_lo) r_lo <= i_sample;
                if (i_sample > r_hi) r_hi <= i_sample;
            end
        end
    end

    // differences against the low bound, both non-negative after the clamp
    assign diff_d = {r_xs[mmrb_pkg::SampleW-1], r_xs} - {r_lo[mmrb_pkg::SampleW-1], r_lo};
    assign diff_r = {r_hi[mmrb_pkg::SampleW-1], r_hi} - {r_lo[mmrb_pkg::SampleW-1], r_lo};

    // numerator d*510 + range as (d << 9) - (d << 1) + range
    assign num = {r_d, 9'b0}
               - {{(mmrb_pkg::NumW-mmrb_pkg::RangeW-1){1'b0}}, r_d, 1'b0}
               + {{(mmrb_pkg::NumW-mmrb_pkg::RangeW){1'b0}}, r_range};

    // one restoring divide step
    assign rem_sh  = {r_rem, r_nlow[mmrb_pkg::QuotBits-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    // convert path registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_sample;
        end
        if (i_cmd.clamp) begin
            if (r_x < r_lo) begin
                r_xs <= r_lo;
            end else if (r_x > r_hi) begin
                r_xs <= r_hi;
            end else begin
                r_xs <= r_x;
            end
        end
        if (i_cmd.prep) begin
            r_d     <= diff_d[mmrb_pkg::RangeW-1:0];
            r_range <= diff_r[mmrb_pkg::RangeW-1:0];
        end
        if (i_cmd.num) begin
            // quotient stays below 256, so the top bits already sit below the divisor
            r_rem  <= num[mmrb_pkg::NumW-1:mmrb_pkg::QuotBits];
            r_nlow <= num[mmrb_pkg::QuotBits-1:0];
            r_den  <= {r_range, 1'b0};
            r_zero <= (r_range == '0);
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_sub[mmrb_pkg::RemW-1:0] : rem_sh[mmrb_pkg::RemW-1:0];
            r_nlow <= {r_nlow[mmrb_pkg::QuotBits-2:0], 1'b0};
            r_q    <= {r_q[mmrb_pkg::QuotBits-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_out_byte <= r_zero ? '0 : r_q;
        end
    end

    // divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.num) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_last = (r_cnt == mmrb_pkg::CntW'(mmrb_pkg::QuotBits - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_byte_value   = r_out_byte;

endmodule

// ===== design/min_max_rescale_to_byte_top.sv =====
// measure word: bounds updated at acceptance, input stays ready, no output word
// convert word: clamp, prepare, numerator and divide steps, then the output word is loaded
// once its register is free; no word is taken before then; 8-step restoring divider
// an output word may wait in its register while the next word is accepted
// synchronous active-low reset clears both bounds to zero and empties the output
// ----------------------------------------------------------------------------
// min_max_rescale_to_byte_top
// rescales Q16.16 samples to bytes against a tracked minimum and maximum
// ----------------------------------------------------------------------------
module min_max_rescale_to_byte_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic                                i_first,
    input  logic signed [mmrb_pkg::SampleW-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mmrb_pkg::ByteW-1:0]          o_byte_value
);

    mmrb_pkg::t_cmd cmd;
    mmrb_pkg::t_sts sts;

    // sequencer
    mmrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    mmrb_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_first      (i_first),
        .i_sample     (i_sample),
        .i_out_ready  (i_out_ready),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_byte_value (o_byte_value)
    );

endmodule

// ===== design/mmrb_chk.sv =====
// ----------------------------------------------------------------------------
// mmrb_chk
// port-level checks for the rescale block, bound to the top level
// ----------------------------------------------------------------------------
module mmrb_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_kind,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [mmrb_pkg::ByteW-1:0]          o_byte_value
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_value))
        else $error("output word changed while stalled");

    // a convert word keeps the input side busy
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == mmrb_pkg::KindConvert) |=> !o_in_ready)
        else $error("input taken during a convert");

    // a measure word finishes in its own cycle
    a_measure_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == mmrb_pkg::KindMeasure) |=> o_in_ready)
        else $error("measure word stalled the input");

    // a new output word only comes out of a convert in flight
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output word without a convert");

endmodule

bind min_max_rescale_to_byte_top mmrb_chk u_mmrb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_byte_value (o_byte_value)
);
